@@ src/png_stored_stream_encoder_defines.svh @@
// assertion macros for the stored stream encoder
`ifndef PNG_STORED_STREAM_ENCODER_DEFINES_SVH
`define PNG_STORED_STREAM_ENCODER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define PNGSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PNGSE_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNGSE_ASSERT(lbl, prop, msg)
`define PNGSE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/pngse_pkg.sv @@
package pngse_pkg;

	localparam int DEF_MAX_DIMENSION = 16384;
	localparam int PADDR_W = 4;
	localparam int CNT_W = 6;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_CHANNELS = 2'd2;

	localparam logic [CNT_W-1:0] HEAD_LAST = 6'd42;
	localparam logic [CNT_W-1:0] BLK_LAST  = 6'd4;
	localparam logic [CNT_W-1:0] TRL_LAST  = 6'd19;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [16:0] ADLER_MOD = 17'd65521;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL,
		S_DIVI,
		S_DIV,
		S_ZLEN,
		S_HEAD,
		S_BLK,
		S_RAW,
		S_TRL
	} state_t;

	typedef struct packed {
		logic go;
		logic crc_on;
		logic crc_init;
		logic adler_on;
		logic adler_init;
	} check_ctl_t;

	function automatic logic [7:0] colour_of(input logic [2:0] c);
		case (c)
			3'd2: colour_of = 8'd4;
			3'd3: colour_of = 8'd2;
			3'd4: colour_of = 8'd6;
			default: colour_of = 8'd0;
		endcase
	endfunction

endpackage

@@ src/pngse_if.sv @@
interface pngse_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_byte;
	modport source(output valid, output pixel_byte, input ready);
	modport sink(input valid, input pixel_byte, output ready);
endinterface

interface pngse_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last_of_item;
	logic       end_of_image;
	modport source(output valid, output out_byte, output last_of_item, output end_of_image,
		input ready);
	modport sink(input valid, input out_byte, input last_of_item, input end_of_image,
		output ready);
endinterface

@@ src/pngse_check.sv @@
module pngse_check
	import pngse_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  check_ctl_t  ctl,
	input  logic [7:0]  data,
	output logic [31:0] crc,
	output logic [15:0] adler_a,
	output logic [15:0] adler_b
);

	logic [31:0] crc_q;
	logic [15:0] a_q;
	logic [15:0] b_q;
	logic [31:0] crc_d;
	logic [16:0] a_sum;
	logic [16:0] a_red;
	logic [16:0] b_sum;
	logic [16:0] b_red;

	always_comb begin
		crc_d = (ctl.crc_init ? 32'hFFFFFFFF : crc_q) ^ {24'd0, data};
		for (int k = 0; k < 8; k++) begin
			crc_d = crc_d[0] ? ((crc_d >> 1) ^ CRC_POLY) : (crc_d >> 1);
		end
	end

	always_comb begin
		a_sum = {1'b0, a_q} + {9'd0, data};
		a_red = (a_sum >= ADLER_MOD) ? a_sum - ADLER_MOD : a_sum;
		b_sum = {1'b0, b_q} + a_red;
		b_red = (b_sum >= ADLER_MOD) ? b_sum - ADLER_MOD : b_sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= 32'hFFFFFFFF;
			a_q <= 16'd1;
			b_q <= 16'd0;
		end else begin
			if (ctl.go && ctl.crc_on) begin
				crc_q <= crc_d;
			end
			if (ctl.adler_init) begin
				a_q <= 16'd1;
				b_q <= 16'd0;
			end else if (ctl.go && ctl.adler_on) begin
				a_q <= a_red[15:0];
				b_q <= b_red[15:0];
			end
		end
	end

	assign crc = crc_q;
	assign adler_a = a_q;
	assign adler_b = b_q;

endmodule

@@ src/png_stored_stream_encoder.sv @@
// PNG stored stream encoder.
// Sample bytes enter on in_ch (valid/ready), row-major with channels
// interleaved; PNG file bytes leave on out_ch, one per transfer, with
// last_of_item on the final byte caused by an input byte and end_of_image
// on the last byte of the file. Width, height and channel count are written
// over the APB port before an image and latched at its first sample.
// Output bytes come from a byte sequencer; an input byte is taken only
// while the sequencer is idle. One input causes one output byte for a
// plain sample, one more (the filter byte) at a row start, and at each
// block start a turn-around step, then the 5 block header bytes; the image
// end adds 20 trailer bytes. The first sample of an image adds length
// arithmetic (a multiply, a division set-up, iterations of the block-count
// reduction, the zlib length) and 43 header bytes ahead of its first
// block start.
// A single sample image defers its 20 byte trailer to the next input byte,
// which is dropped.
// A stalled receiver holds the output register; the sequencer waits on it.
// Reset returns to the start of an image with default registers; no
// clearing pass is needed.
`include "png_stored_stream_encoder_defines.svh"

module png_stored_stream_encoder
	import pngse_pkg::*;
#(
	parameter int MAX_DIMENSION = DEF_MAX_DIMENSION
) (
	input  logic               clk,
	input  logic               arst_n,
	pngse_in_if.sink           in_ch,
	pngse_out_if.source        out_ch,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int RL_W  = DIM_W + 3;
	localparam int RAW_W = 2 * DIM_W + 4;
	localparam int DV_W  = RAW_W + 17;
	localparam int ZW    = DV_W + 3;

	state_t state_q, state_d;

	logic [14:0] cfg_w_q, cfg_h_q;
	logic [2:0]  cfg_c_q;

	logic [DIM_W-1:0] w_q, h_q, rows_q;
	logic [2:0]       c_q;
	logic [RL_W-1:0]  row_len_q, col_q;
	logic [RAW_W-1:0] raw_q, raw_left_q;
	logic [DV_W-1:0]  div_q_q, div_r_q;
	logic [31:0]      idat_q;
	logic [15:0]      blk_left_q;
	logic [CNT_W-1:0] cnt_q;
	logic             active_q, tail_q, first_q, filt_q;
	logic [7:0]       pix_q;

	logic       ov_q, olast_q, oeoi_q;
	logic [7:0] ob_q;

	logic       emit_v, go, in_acc;
	logic [7:0] eb;
	logic       e_last, e_eoi;
	check_ctl_t ctl;

	logic [31:0] crc;
	logic [15:0] adler_a, adler_b;

	logic [DIM_W-1:0] w_cl, h_cl;
	logic [2:0]       c_cl;
	logic [RAW_W+16:0] raw_x;
	logic [15:0]      blen;
	logic             blk_final;
	logic             img_end;
	logic [DV_W-1:0]  x_div, r_hi;
	logic [ZW-1:0]    zsum;

	assign pready = 1'b1;
	assign in_ch.ready = (state_q == S_IDLE);
	assign in_acc = in_ch.valid && in_ch.ready;
	assign go = emit_v && (!ov_q || out_ch.ready);

	assign out_ch.valid = ov_q;
	assign out_ch.out_byte = ob_q;
	assign out_ch.last_of_item = olast_q;
	assign out_ch.end_of_image = oeoi_q;

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:    prdata = {17'd0, cfg_w_q};
			REG_HEIGHT:   prdata = {17'd0, cfg_h_q};
			REG_CHANNELS: prdata = {29'd0, cfg_c_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_comb begin
		if (cfg_w_q == 15'd0) begin
			w_cl = DIM_W'(1);
		end else if ({17'd0, cfg_w_q} > 32'(MAX_DIMENSION)) begin
			w_cl = DIM_W'(MAX_DIMENSION);
		end else begin
			w_cl = DIM_W'(cfg_w_q);
		end
		if (cfg_h_q == 15'd0) begin
			h_cl = DIM_W'(1);
		end else if ({17'd0, cfg_h_q} > 32'(MAX_DIMENSION)) begin
			h_cl = DIM_W'(MAX_DIMENSION);
		end else begin
			h_cl = DIM_W'(cfg_h_q);
		end
		if (cfg_c_q == 3'd0) begin
			c_cl = 3'd1;
		end else if (cfg_c_q > 3'd4) begin
			c_cl = 3'd4;
		end else begin
			c_cl = cfg_c_q;
		end
	end

	assign raw_x = (RAW_W + 17)'(raw_left_q);
	assign blk_final = (raw_x <= (RAW_W + 17)'(65535));
	assign blen = blk_final ? raw_x[15:0] : 16'hFFFF;
	assign img_end = !filt_q && (col_q == RL_W'(1)) && (rows_q == DIM_W'(1));
	assign x_div = DV_W'(raw_q) + DV_W'(65534);
	assign r_hi = div_r_q >> 16;
	assign zsum = ZW'(6) + ZW'(raw_q) + (ZW'(div_q_q) << 2) + ZW'(div_q_q);

	function automatic logic [7:0] head_byte(
		input logic [CNT_W-1:0] i,
		input logic [31:0] w32,
		input logic [31:0] h32,
		input logic [7:0] colour,
		input logic [31:0] crcx,
		input logic [31:0] ilen
	);
		case (i)
			6'd0:  head_byte = 8'h89;
			6'd1:  head_byte = 8'h50;
			6'd2:  head_byte = 8'h4E;
			6'd3:  head_byte = 8'h47;
			6'd4:  head_byte = 8'h0D;
			6'd5:  head_byte = 8'h0A;
			6'd6:  head_byte = 8'h1A;
			6'd7:  head_byte = 8'h0A;
			6'd11: head_byte = 8'd13;
			6'd12: head_byte = 8'h49;
			6'd13: head_byte = 8'h48;
			6'd14: head_byte = 8'h44;
			6'd15: head_byte = 8'h52;
			6'd16: head_byte = w32[31:24];
			6'd17: head_byte = w32[23:16];
			6'd18: head_byte = w32[15:8];
			6'd19: head_byte = w32[7:0];
			6'd20: head_byte = h32[31:24];
			6'd21: head_byte = h32[23:16];
			6'd22: head_byte = h32[15:8];
			6'd23: head_byte = h32[7:0];
			6'd24: head_byte = 8'd8;
			6'd25: head_byte = colour;
			6'd29: head_byte = crcx[31:24];
			6'd30: head_byte = crcx[23:16];
			6'd31: head_byte = crcx[15:8];
			6'd32: head_byte = crcx[7:0];
			6'd33: head_byte = ilen[31:24];
			6'd34: head_byte = ilen[23:16];
			6'd35: head_byte = ilen[15:8];
			6'd36: head_byte = ilen[7:0];
			6'd37: head_byte = 8'h49;
			6'd38: head_byte = 8'h44;
			6'd39: head_byte = 8'h41;
			6'd40: head_byte = 8'h54;
			6'd41: head_byte = 8'h78;
			6'd42: head_byte = 8'h01;
			default: head_byte = 8'h00;
		endcase
	endfunction

	// byte lane: what the sequencer emits this cycle
	always_comb begin
		emit_v = 1'b0;
		eb = 8'h00;
		e_last = 1'b0;
		e_eoi = 1'b0;
		ctl = '0;
		case (state_q)
			S_HEAD: begin
				emit_v = 1'b1;
				eb = head_byte(cnt_q, 32'(w_q), 32'(h_q), colour_of(c_q), ~crc, idat_q);
				ctl.crc_on = ((cnt_q >= 6'd12) && (cnt_q <= 6'd28)) || (cnt_q >= 6'd37);
				ctl.crc_init = (cnt_q == 6'd12) || (cnt_q == 6'd37);
			end
			S_BLK: begin
				emit_v = 1'b1;
				ctl.crc_on = 1'b1;
				case (cnt_q)
					6'd0: eb = {7'd0, blk_final};
					6'd1: eb = blen[7:0];
					6'd2: eb = blen[15:8];
					6'd3: eb = ~blen[7:0];
					default: eb = ~blen[15:8];
				endcase
			end
			S_RAW: begin
				if (blk_left_q != 16'd0) begin
					emit_v = 1'b1;
					eb = filt_q ? 8'h00 : pix_q;
					ctl.crc_on = 1'b1;
					ctl.adler_on = 1'b1;
					e_last = !filt_q && !(img_end && !first_q);
				end
			end
			S_TRL: begin
				emit_v = 1'b1;
				case (cnt_q)
					6'd0: eb = adler_b[15:8];
					6'd1: eb = adler_b[7:0];
					6'd2: eb = adler_a[15:8];
					6'd3: eb = adler_a[7:0];
					6'd4, 6'd16: eb = ~crc[31:24];
					6'd5, 6'd17: eb = ~crc[23:16];
					6'd6, 6'd18: eb = ~crc[15:8];
					6'd7, 6'd19: eb = ~crc[7:0];
					6'd12: eb = 8'h49;
					6'd13: eb = 8'h45;
					6'd14: eb = 8'h4E;
					6'd15: eb = 8'h44;
					default: eb = 8'h00;
				endcase
				ctl.crc_on = (cnt_q <= 6'd3) || ((cnt_q >= 6'd12) && (cnt_q <= 6'd15));
				ctl.crc_init = (cnt_q == 6'd12);
				e_last = (cnt_q == TRL_LAST);
				e_eoi = (cnt_q == TRL_LAST);
			end
			default: begin
				emit_v = 1'b0;
			end
		endcase
		ctl.go = go;
		ctl.adler_init = in_acc && !active_q && !tail_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					if (tail_q) begin
						state_d = S_TRL;
					end else if (!active_q) begin
						state_d = S_MUL;
					end else begin
						state_d = S_RAW;
					end
				end
			end
			S_MUL:  state_d = S_DIVI;
			S_DIVI: state_d = S_DIV;
			S_DIV: begin
				if ((r_hi == '0) && (div_r_q != DV_W'(65535))) begin
					state_d = S_ZLEN;
				end
			end
			S_ZLEN: state_d = S_HEAD;
			S_HEAD: begin
				if (go && (cnt_q == HEAD_LAST)) begin
					state_d = S_RAW;
				end
			end
			S_BLK: begin
				if (go && (cnt_q == BLK_LAST)) begin
					state_d = S_RAW;
				end
			end
			S_RAW: begin
				if (blk_left_q == 16'd0) begin
					state_d = S_BLK;
				end else if (go && !filt_q) begin
					state_d = (img_end && !first_q) ? S_TRL : S_IDLE;
				end
			end
			S_TRL: begin
				if (go && (cnt_q == TRL_LAST)) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cfg_w_q <= 15'd1;
			cfg_h_q <= 15'd1;
			cfg_c_q <= 3'd4;
			cnt_q <= '0;
			active_q <= 1'b0;
			tail_q <= 1'b0;
			first_q <= 1'b0;
			filt_q <= 1'b0;
			blk_left_q <= 16'd0;
			raw_left_q <= '0;
			col_q <= '0;
			rows_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (psel && penable && pwrite) begin
				case (paddr[3:2])
					REG_WIDTH:    cfg_w_q <= pwdata[14:0];
					REG_HEIGHT:   cfg_h_q <= pwdata[14:0];
					REG_CHANNELS: cfg_c_q <= pwdata[2:0];
					default: ;
				endcase
			end
			if (go) begin
				ov_q <= 1'b1;
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc && !tail_q) begin
						filt_q <= !active_q || (col_q == '0);
						if (!active_q) begin
							active_q <= 1'b1;
							first_q <= 1'b1;
							col_q <= '0;
							blk_left_q <= 16'd0;
						end
					end
				end
				S_MUL: rows_q <= h_q;
				S_ZLEN: raw_left_q <= raw_q;
				S_HEAD: begin
					if (go) begin
						cnt_q <= (cnt_q == HEAD_LAST) ? '0 : cnt_q + 1'b1;
					end
				end
				S_BLK: begin
					if (go) begin
						cnt_q <= (cnt_q == BLK_LAST) ? '0 : cnt_q + 1'b1;
						if (cnt_q == BLK_LAST) begin
							blk_left_q <= blen;
						end
					end
				end
				S_RAW: begin
					if (go) begin
						blk_left_q <= blk_left_q - 16'd1;
						raw_left_q <= raw_left_q - 1'b1;
						if (filt_q) begin
							col_q <= row_len_q;
							filt_q <= 1'b0;
						end else begin
							col_q <= col_q - 1'b1;
							first_q <= 1'b0;
							if (col_q == RL_W'(1)) begin
								rows_q <= rows_q - 1'b1;
							end
							if (img_end) begin
								active_q <= 1'b0;
								tail_q <= first_q;
							end
						end
					end
				end
				S_TRL: begin
					if (go) begin
						cnt_q <= (cnt_q == TRL_LAST) ? '0 : cnt_q + 1'b1;
						if (cnt_q == TRL_LAST) begin
							tail_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (go) begin
			ob_q <= eb;
			olast_q <= e_last;
			oeoi_q <= e_eoi;
		end
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					pix_q <= in_ch.pixel_byte;
					if (!active_q && !tail_q) begin
						w_q <= w_cl;
						h_q <= h_cl;
						c_q <= c_cl;
						row_len_q <= RL_W'(w_cl) * RL_W'(c_cl);
					end
				end
			end
			S_MUL: raw_q <= RAW_W'(RAW_W'(h_q) * RAW_W'({1'b0, row_len_q} + 1'b1));
			S_DIVI: begin
				div_q_q <= x_div >> 16;
				div_r_q <= DV_W'(x_div[15:0]) + (x_div >> 16);
			end
			S_DIV: begin
				if (r_hi != '0) begin
					div_q_q <= div_q_q + r_hi;
					div_r_q <= DV_W'(div_r_q[15:0]) + r_hi;
				end else if (div_r_q == DV_W'(65535)) begin
					div_q_q <= div_q_q + 1'b1;
					div_r_q <= '0;
				end
			end
			S_ZLEN: idat_q <= 32'(zsum);
			default: ;
		endcase
	end

	pngse_check u_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.data    (eb),
		.crc     (crc),
		.adler_a (adler_a),
		.adler_b (adler_b)
	);

	`PNGSE_ASSERT(a_blk_hdr_when_empty, (state_q == S_BLK) |-> (blk_left_q == 16'd0), "block header with bytes left")
	`PNGSE_ASSERT(a_raw_left_nonzero, (state_q == S_RAW) |-> (raw_left_q != '0), "raw byte past end of stream")
	`PNGSE_ASSERT(a_tail_inactive, tail_q |-> !active_q, "deferred trailer inside an image")
	`PNGSE_ASSERT(a_out_hold, (ov_q && !out_ch.ready) |=> (ov_q && $stable(ob_q)), "output lost under stall")
	`PNGSE_ASSERT_ALWAYS(a_eoi_last, (ov_q && oeoi_q) |-> olast_q, "end of image without last")

endmodule

@@ tb/png_stored_stream_encoder_tb.sv @@
module png_stored_stream_encoder_tb
	import pngse_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WDOG_LIMIT = 4000;
	localparam int PNG_MAX_DIM = 16384;

	typedef enum logic [1:0] {IMG_START, IMG_DATA, IMG_TAIL} img_phase_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_item;
		logic       end_of_image;
	} png_byte_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	pngse_in_if  in_ch();
	pngse_out_if out_ch();

	png_stored_stream_encoder dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// predictor state
	logic [14:0] cfg_width, cfg_height;
	logic [2:0]  cfg_chan;
	img_phase_t  img_phase;
	logic [31:0] col_left, rows_left, blk_left, raw_left, row_len, idat_len;
	logic [31:0] adler_a, adler_b, file_crc;
	logic [7:0]  step_q[$];
	png_byte_t   file_bytes_q[$];

	int  err_cnt = 0;
	int  items_sent = 0;
	bit  tx_idle = 1'b1;
	bit  rx_idle = 1'b1;
	int  quiet_cycles = 0;

	function automatic void put(input logic [7:0] b, input bit crc_on);
		step_q.push_back(b);
		if (crc_on) begin
			file_crc ^= {24'd0, b};
			for (int k = 0; k < 8; k++)
				file_crc = file_crc[0] ? (file_crc >> 1) ^ CRC_POLY : file_crc >> 1;
		end
	endfunction

	function automatic void put32(input logic [31:0] v, input bit crc_on);
		put(v[31:24], crc_on);
		put(v[23:16], crc_on);
		put(v[15:8], crc_on);
		put(v[7:0], crc_on);
	endfunction

	function automatic void chunk_open(input logic [31:0] len, input string tag);
		put32(len, 1'b0);
		file_crc = '1;
		for (int i = 0; i < 4; i++)
			put(tag[i], 1'b1);
	endfunction

	function automatic void put_raw(input logic [7:0] b);
		logic [15:0] blen;
		if (blk_left == 0) begin
			blen = (raw_left > 65535) ? 16'hffff : raw_left[15:0];
			put((raw_left <= 65535) ? 8'd1 : 8'd0, 1'b1);
			put(blen[7:0], 1'b1);
			put(blen[15:8], 1'b1);
			put(~blen[7:0], 1'b1);
			put(~blen[15:8], 1'b1);
			blk_left = {16'd0, blen};
		end
		put(b, 1'b1);
		adler_a += b;
		if (adler_a >= ADLER_MOD) adler_a -= ADLER_MOD;
		adler_b += adler_a;
		if (adler_b >= ADLER_MOD) adler_b -= ADLER_MOD;
		if (blk_left > 0) blk_left--;
		if (raw_left > 0) raw_left--;
	endfunction

	function automatic void put_trailer();
		put32({adler_b[15:0], adler_a[15:0]}, 1'b1);
		put32(~file_crc, 1'b0);
		chunk_open(32'd0, "IEND");
		put32(~file_crc, 1'b0);
	endfunction

	function automatic void open_image();
		logic [31:0] w, h, c;
		longint raw, blocks, zlen;
		logic [7:0] colour;
		w = cfg_width;
		h = cfg_height;
		c = cfg_chan;
		if (w < 1) w = 1;
		if (w > PNG_MAX_DIM) w = PNG_MAX_DIM;
		if (h < 1) h = 1;
		if (h > PNG_MAX_DIM) h = PNG_MAX_DIM;
		if (c < 1) c = 1;
		if (c > 4) c = 4;
		colour = (c == 2) ? 8'd4 : (c == 3) ? 8'd2 : (c == 4) ? 8'd6 : 8'd0;
		row_len = w * c;
		raw = longint'(h) * (longint'(row_len) + 1);
		blocks = (raw + 65534) / 65535;
		zlen = 6 + raw + 5 * blocks;
		idat_len = zlen[31:0];
		raw_left = raw[31:0];
		rows_left = h;
		col_left = 0;
		blk_left = 0;
		adler_a = 1;
		adler_b = 0;
		put(8'h89, 1'b0); put("P", 1'b0); put("N", 1'b0); put("G", 1'b0);
		put(8'h0d, 1'b0); put(8'h0a, 1'b0); put(8'h1a, 1'b0); put(8'h0a, 1'b0);
		chunk_open(32'd13, "IHDR");
		put32(w, 1'b1);
		put32(h, 1'b1);
		put(8'd8, 1'b1);
		put(colour, 1'b1);
		put(8'd0, 1'b1);
		put(8'd0, 1'b1);
		put(8'd0, 1'b1);
		put32(~file_crc, 1'b0);
		chunk_open(idat_len, "IDAT");
		put(8'h78, 1'b1);
		put(8'h01, 1'b1);
		img_phase = IMG_DATA;
	endfunction

	function automatic void predict_pixel(input logic [7:0] b);
		bit done;
		png_byte_t pb;
		done = 1'b0;
		step_q.delete();
		if (img_phase == IMG_TAIL) begin
			put_trailer();
			img_phase = IMG_START;
			done = 1'b1;
		end else begin
			if (img_phase != IMG_DATA) open_image();
			if (col_left == 0) begin
				put_raw(8'd0);
				col_left = row_len;
			end
			put_raw(b);
			if (col_left > 0) col_left--;
			if (col_left == 0) begin
				if (rows_left > 0) rows_left--;
				if (rows_left == 0) begin
					if (step_q.size() + 20 > 50) begin
						img_phase = IMG_TAIL;
					end else begin
						put_trailer();
						img_phase = IMG_START;
						done = 1'b1;
					end
				end
			end
		end
		foreach (step_q[i]) begin
			pb.out_byte = step_q[i];
			pb.last_of_item = (i == step_q.size() - 1);
			pb.end_of_image = done && (i == step_q.size() - 1);
			file_bytes_q.push_back(pb);
		end
	endfunction

	task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
		err_cnt++;
	endtask

	// output checker and watchdog
	always @(posedge clk) begin
		png_byte_t want;
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (out_ch.valid && out_ch.ready) begin
				if (file_bytes_q.size() == 0) begin
					report("unexpected byte", out_ch.out_byte, 8'h00);
				end else begin
					want = file_bytes_q.pop_front();
					if (out_ch.out_byte !== want.out_byte)
						report("out_byte", out_ch.out_byte, want.out_byte);
					if (out_ch.last_of_item !== want.last_of_item)
						report("last_of_item", out_ch.last_of_item, want.last_of_item);
					if (out_ch.end_of_image !== want.end_of_image)
						report("end_of_image", out_ch.end_of_image, want.end_of_image);
				end
			end
			if (quiet_cycles >= WDOG_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	// receiver stalls
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_idle && $urandom_range(0, 5) == 0) begin
				out_ch.ready = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ch.ready = 1'b1;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
	end

	// called at a falling edge; returns at a falling edge
	task automatic send_pixel(input logic [7:0] b);
		if (tx_idle && $urandom_range(0, 4) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.pixel_byte = b;
		do @(posedge clk); while (!in_ch.ready);
		predict_pixel(b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_ch.valid = 1'b0;
		while (file_bytes_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = PADDR_W'({idx, 2'b00});
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			REG_WIDTH:    cfg_width = val[14:0];
			REG_HEIGHT:   cfg_height = val[14:0];
			REG_CHANNELS: cfg_chan = val[2:0];
			default: ;
		endcase
	endtask

	task automatic setup_image(input int w, input int h, input int c);
		wait_drain();
		reg_write(REG_WIDTH, w);
		reg_write(REG_HEIGHT, h);
		reg_write(REG_CHANNELS, c);
	endtask

	// sends one whole image for the current settings, plus the dropped byte if deferred
	task automatic send_image(input bit pause_mid);
		int w, h, c, n;
		w = (cfg_width < 1) ? 1 : (cfg_width > PNG_MAX_DIM) ? PNG_MAX_DIM : cfg_width;
		h = (cfg_height < 1) ? 1 : (cfg_height > PNG_MAX_DIM) ? PNG_MAX_DIM : cfg_height;
		c = (cfg_chan < 1) ? 1 : (cfg_chan > 4) ? 4 : cfg_chan;
		n = w * h * c;
		for (int i = 0; i < n; i++) begin
			if (pause_mid && i == n / 2) wait_drain();
			send_pixel($urandom_range(0, 255));
		end
		if (img_phase == IMG_TAIL) send_pixel($urandom_range(0, 255));
	endtask

	task automatic test_default_image();
		send_pixel(8'h00);
		send_pixel(8'hff);
		send_pixel(8'h80);
		send_pixel(8'h7f);
	endtask

	task automatic test_single_sample();
		setup_image(1, 1, 1);
		send_pixel(8'haa);
		send_pixel(8'h55);
		setup_image(0, 0, 0);
		send_pixel(8'hff);
		send_pixel(8'h00);
	endtask

	task automatic test_clamped_channels();
		setup_image(1, 2, 7);
		send_image(1'b0);
		setup_image(2, 1, 2);
		send_image(1'b0);
		setup_image(1, 1, 3);
		send_image(1'b0);
	endtask

	task automatic test_wide_row();
		setup_image(16, 1, 4);
		send_image(1'b0);
	endtask

	task automatic test_random_images();
		int start;
		bit paused;
		start = items_sent;
		paused = 1'b0;
		while (items_sent - start < 190) begin
			if (items_sent - start > 140) begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			setup_image($urandom_range(1, 7), $urandom_range(1, 5), $urandom_range(1, 4));
			send_image(!paused && items_sent - start > 60);
			if (items_sent - start > 60) paused = 1'b1;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.pixel_byte = 8'd0;
		cfg_width = 15'd1;
		cfg_height = 15'd1;
		cfg_chan = 3'd4;
		img_phase = IMG_START;
		col_left = 0; rows_left = 0; blk_left = 0; raw_left = 0;
		row_len = 0; idat_len = 0;
		adler_a = 1; adler_b = 0; file_crc = '1;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_default_image();
		test_single_sample();
		test_clamped_channels();
		test_wide_row();
		test_random_images();

		wait_drain();
		if (err_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+src
src/pngse_pkg.sv
src/pngse_if.sv
src/pngse_check.sv
src/png_stored_stream_encoder.sv
tb/png_stored_stream_encoder_tb.sv
